// File: rtl/divisor_count_and_sum_assert.svh
// Assertion macros shared by the divisor count and sum block.
`ifndef DIVISOR_COUNT_AND_SUM_ASSERT_SVH
`define DIVISOR_COUNT_AND_SUM_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under synchronous reset.
`define DCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication under synchronous reset.
`define DCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
// Invariant under synchronous reset.
`define DCS_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");
`else
`define DCS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define DCS_ASSERT_NEXT(name, clk, rst, ante, cons)
`define DCS_ASSERT_ALWAYS(name, clk, rst, expr)
`endif
`endif

// File: rtl/dcs_pkg.sv
// Types and constants shared by the divisor count and sum block.
package dcs_pkg;

   localparam int COUNT_W = 11;
   localparam int SUM_W   = 36;
   localparam int EXP_W   = 6;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // take a new item, reset accumulators
      logic trial_init;  // clear exponent, power and series for a new divisor
      logic div_start;   // divide residual by trial divisor
      logic divide_out;  // replace residual by quotient, bump exponent, power*p
      logic power_update;// take power product, add to series
      logic count_fold;  // fold exponent into count, start sum*series
      logic sum_update;  // take sum product
      logic advance;     // step to the next trial divisor
      logic tail_fold;   // fold leftover prime into count and sum
   } dcs_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sq_le_res;
      logic div_done;
      logic rem_zero;
      logic mul_done;
      logic exp_nonzero;
      logic res_gt_one;
   } dcs_status_type;

endpackage

// File: rtl/dcs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module dcs_div import dcs_pkg::*; #(
   parameter int N_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] dividend,
   input  logic [N_BITS-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [N_BITS-1:0] quotient,
   output logic [N_BITS-1:0] remainder
);

   localparam int CW = $clog2(N_BITS + 1);

   logic [N_BITS-1:0] rem_ff, rem_in;
   logic [N_BITS-1:0] quo_ff, quo_in;
   logic [N_BITS-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [N_BITS:0]   shifted;
   logic              ge;

   // Shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[N_BITS-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CW'(N_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? N_BITS'(shifted - {1'b0, dvs_ff}) : shifted[N_BITS-1:0];
         quo_in = {quo_ff[N_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign busy      = run_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/dcs_mul.sv
// Shift-and-add multiplier modulo 2^SUM_W, one multiplier bit per cycle.
module dcs_mul import dcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] op_a,
   input  logic [SUM_W-1:0] op_b,
   output logic             busy,
   output logic             done,
   output logic [SUM_W-1:0] product
);

   logic [SUM_W-1:0] a_ff, a_in;
   logic [SUM_W-1:0] b_ff, b_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   // Add the shifted multiplicand for each set multiplier bit; stop when none remain
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[SUM_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[SUM_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign busy    = run_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/dcs_dp.sv
// Datapath: residual, trial divisor, accumulators, divider and multiplier.
`include "divisor_count_and_sum_assert.svh"
module dcs_dp import dcs_pkg::*; #(
   parameter int N_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  dcs_cmd_type        cmd,
   input  logic [N_BITS-1:0]  number,
   output dcs_status_type     status,
   output logic [COUNT_W-1:0] divisor_count,
   output logic [SUM_W-1:0]   divisor_sum
);

   logic [N_BITS-1:0]        residual_ff, residual_in;
   logic [N_BITS-1:0]        trial_ff, trial_in;
   logic [N_BITS+1:0]        square_ff, square_in;
   logic [EXP_W-1:0]         exp_ff, exp_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SUM_W-1:0]         power_ff, power_in;
   logic [SUM_W-1:0]         series_ff, series_in;

   logic [N_BITS+SUM_W-1:0]  trial_ext, residual_ext;
   logic [SUM_W-1:0]         tail_b;
   logic [EXP_W:0]           exp_inc;
   logic [COUNT_W+EXP_W:0]   count_prod;

   logic                     div_busy, div_done;
   logic [N_BITS-1:0]        quotient, remainder;
   logic                     mul_start, mul_busy, mul_done;
   logic [SUM_W-1:0]         mul_a, mul_b, product;

   // Low SUM_W bits of the divisor and residual feed the modular multiplier
   assign trial_ext    = {{SUM_W{1'b0}}, trial_ff};
   assign residual_ext = {{SUM_W{1'b0}}, residual_ff};
   assign tail_b       = residual_ext[SUM_W-1:0] + 1'b1;
   assign exp_inc      = {1'b0, exp_ff} + 1'b1;
   assign count_prod   = count_ff * exp_inc;

   // Select multiplier operands by command
   assign mul_start = cmd.divide_out | cmd.count_fold | cmd.tail_fold;
   assign mul_a     = cmd.divide_out ? power_ff : sum_ff;
   assign mul_b     = cmd.divide_out ? trial_ext[SUM_W-1:0] :
                      (cmd.tail_fold ? tail_b : series_ff);

   dcs_div #(.N_BITS(N_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (residual_ff),
      .divisor   (trial_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   dcs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (product)
   );

   // Next values of the working registers
   always_comb begin
      residual_in = residual_ff;
      trial_in    = trial_ff;
      square_in   = square_ff;
      exp_in      = exp_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      power_in    = power_ff;
      series_in   = series_ff;
      if (cmd.load) begin
         residual_in = number;
         trial_in    = N_BITS'(2);
         square_in   = (N_BITS+2)'(4);
         count_in    = COUNT_W'(1);
         sum_in      = SUM_W'(1);
      end
      if (cmd.trial_init) begin
         exp_in    = '0;
         power_in  = SUM_W'(1);
         series_in = SUM_W'(1);
      end
      if (cmd.divide_out) begin
         residual_in = quotient;
         exp_in      = exp_ff + 1'b1;
      end
      if (cmd.power_update) begin
         power_in  = product;
         series_in = series_ff + product;
      end
      if (cmd.count_fold) begin
         count_in = count_prod[COUNT_W-1:0];
      end
      if (cmd.tail_fold) begin
         count_in = {count_ff[COUNT_W-2:0], 1'b0};
      end
      if (cmd.sum_update) begin
         sum_in = product;
      end
      // (d+1)^2 = d^2 + 2d + 1
      if (cmd.advance) begin
         trial_in  = trial_ff + 1'b1;
         square_in = square_ff + {1'b0, trial_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      residual_ff <= residual_in;
      trial_ff    <= trial_in;
      square_ff   <= square_in;
      exp_ff      <= exp_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      power_ff    <= power_in;
      series_ff   <= series_in;
   end

   // Report to the controller
   assign status.sq_le_res   = square_ff <= {2'b00, residual_ff};
   assign status.div_done    = div_done;
   assign status.rem_zero    = remainder == '0;
   assign status.mul_done    = mul_done;
   assign status.exp_nonzero = exp_ff != '0;
   assign status.res_gt_one  = residual_ff > N_BITS'(1);

   assign divisor_count = count_ff;
   assign divisor_sum   = sum_ff;

   `DCS_ASSERT_IMPL(a_div_not_restarted, clock, reset, cmd.div_start, !div_busy)
   `DCS_ASSERT_IMPL(a_mul_not_restarted, clock, reset, mul_start, !mul_busy)
   `DCS_ASSERT_NEXT(a_trial_from_two, clock, reset, cmd.load, trial_ff == N_BITS'(2))

endmodule

// File: rtl/dcs_ctrl.sv
// Controller: sequences trial division and prime folding for one item.
`include "divisor_count_and_sum_assert.svh"
module dcs_ctrl import dcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  dcs_status_type status,
   output dcs_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   typedef enum logic [3:0] {
      IDLE,
      CHECK,
      DIV,
      MUL_POW,
      FOLD,
      MUL_SUM,
      TAIL,
      MUL_TAIL,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.sq_le_res) begin
               cmd.trial_init = 1'b1;
               cmd.div_start  = 1'b1;
               state_in       = DIV;
            end else begin
               state_in = TAIL;
            end
         end
         DIV: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.divide_out = 1'b1;
                  state_in       = MUL_POW;
               end else begin
                  state_in = FOLD;
               end
            end
         end
         MUL_POW: begin
            if (status.mul_done) begin
               cmd.power_update = 1'b1;
               cmd.div_start    = 1'b1;
               state_in         = DIV;
            end
         end
         FOLD: begin
            if (status.exp_nonzero) begin
               cmd.count_fold = 1'b1;
               state_in       = MUL_SUM;
            end else begin
               cmd.advance = 1'b1;
               state_in    = CHECK;
            end
         end
         MUL_SUM: begin
            if (status.mul_done) begin
               cmd.sum_update = 1'b1;
               cmd.advance    = 1'b1;
               state_in       = CHECK;
            end
         end
         TAIL: begin
            if (status.res_gt_one) begin
               cmd.tail_fold = 1'b1;
               state_in      = MUL_TAIL;
            end else begin
               state_in = DONE;
            end
         end
         MUL_TAIL: begin
            if (status.mul_done) begin
               cmd.sum_update = 1'b1;
               state_in       = DONE;
            end
         end
         DONE: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= state_in != IDLE;
         valid_ff <= state_in == DONE;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

   `DCS_ASSERT_IMPL(a_valid_while_busy, clock, reset, valid_ff, busy_ff)
   `DCS_ASSERT_NEXT(a_valid_one_cycle, clock, reset, valid_ff, !valid_ff && !busy_ff)
   `DCS_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy_ff, busy_ff && !valid_ff)

endmodule

// File: rtl/divisor_count_and_sum.sv
// Divisor count and divisor sum of one unsigned number by trial division.
// Work: one division per trial divisor d while d*d <= cofactor, plus one more division
// and one multiply by d per factor divided out, and one multiply per prime folded.
// The shared radix-2 divider dominates the run time.
// One item at a time; busy stays high from acceptance through the result strobe.
// Synchronous reset returns to idle; the receiver cannot stall, rsp_valid lasts one cycle.
module divisor_count_and_sum import dcs_pkg::*; #(
   parameter int N_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [N_BITS-1:0]  req_number,
   output logic               rsp_valid,
   output logic [COUNT_W-1:0] rsp_divisor_count,
   output logic [SUM_W-1:0]   rsp_divisor_sum
);

   dcs_cmd_type    cmd;
   dcs_status_type status;
   logic           busy_int;
   logic           accept;

   // Take an item only from idle
   assign accept = start & ~busy_int;
   assign busy   = busy_int;

   dcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy_int),
      .rsp_valid (rsp_valid)
   );

   dcs_dp #(.N_BITS(N_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .number        (req_number),
      .status        (status),
      .divisor_count (rsp_divisor_count),
      .divisor_sum   (rsp_divisor_sum)
   );

endmodule
